// File: hw/rtl/rcdf_pkg.sv
// shared types and constants for the repeating countdown with fade block
// no dependencies; imported by rcdf_alpha and the top level
`default_nettype none

package rcdf_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int TICK_W      = 16;
  localparam int ALPHA_W     = 8;

  // register indexes on the configuration channel
  localparam logic [CFG_INDEX_W-1:0] REG_DURATION     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_ENABLE  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_ALPHA  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_END_ALPHA    = 3'd4;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_t;

  // fade settings handed to the alpha unit
  typedef struct packed {
    logic               fade_enable;
    logic [ALPHA_W-1:0] start_alpha;
    logic [ALPHA_W-1:0] end_alpha;
  } alpha_cfg_t;

  // alpha unit response
  typedef struct packed {
    logic               done;
    logic [ALPHA_W-1:0] alpha;
  } alpha_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/rcdf_alpha.sv
// alpha interpolation unit: one shared 8 x time-width multiplier, then a
// shift-subtract divider that retires one quotient bit a cycle; uses rcdf_pkg
`default_nettype none

module rcdf_alpha #(
  parameter int TIME_WIDTH = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        req,
  input  wire [TIME_WIDTH-1:0]       elapsed,
  input  wire [TIME_WIDTH-1:0]       remaining,
  input  rcdf_pkg::alpha_cfg_t       cfg,
  output rcdf_pkg::alpha_rsp_t       rsp
);
  import rcdf_pkg::*;

  // numerator stays below 256 * period, so the quotient fits in alpha width
  localparam int NW = TIME_WIDTH + ALPHA_W;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL_E,
    A_MUL_R,
    A_DIV
  } astate_t;

  astate_t               state;
  logic [TIME_WIDTH-1:0] period;
  logic [NW-1:0]         acc;
  logic [NW-1:0]         dsh;
  logic [ALPHA_W-1:0]    quot;
  logic [2:0]            cnt;

  logic [ALPHA_W-1:0]    mul_a;
  logic [TIME_WIDTH-1:0] mul_b;
  logic [NW-1:0]         product;
  logic                  fits;
  logic                  done_next;

  // shared multiplier: end * elapsed first, then start * remaining
  always_comb begin
    mul_a   = (state == A_MUL_E) ? cfg.end_alpha : cfg.start_alpha;
    mul_b   = (state == A_MUL_E) ? elapsed : remaining;
    product = NW'(mul_a) * NW'(mul_b);
    fits    = (acc >= dsh);
    // answer ready: fading off, zero period, or last quotient bit
    done_next = (state == A_IDLE && req && !cfg.fade_enable) ||
                (state == A_MUL_E && period == '0) ||
                (state == A_DIV && cnt == 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= done_next;
      unique case (state)
        A_IDLE: begin
          if (req) begin
            if (!cfg.fade_enable) begin
              rsp.alpha <= cfg.start_alpha;
            end else begin
              period <= elapsed + remaining;
              state  <= A_MUL_E;
            end
          end
        end
        A_MUL_E: begin
          if (period == '0) begin
            rsp.alpha <= cfg.end_alpha;
            state     <= A_IDLE;
          end else begin
            // half the period added up front rounds halves up
            acc   <= product + NW'(period >> 1);
            state <= A_MUL_R;
          end
        end
        A_MUL_R: begin
          acc   <= acc + product;
          dsh   <= NW'({period, 7'b0});
          cnt   <= 3'd7;
          quot  <= '0;
          state <= A_DIV;
        end
        A_DIV: begin
          if (fits) begin
            acc <= acc - dsh;
          end
          quot <= {quot[ALPHA_W-2:0], fits};
          dsh  <= dsh >> 1;
          cnt  <= cnt - 3'd1;
          if (cnt == 3'd0) begin
            rsp.alpha <= {quot[ALPHA_W-2:0], fits};
            state     <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/repeating_countdown_with_fade_unit.sv
// repeating countdown timer with linear alpha fade, top level
// depends on rcdf_pkg and rcdf_alpha
`default_nettype none

// A start word (tuser 1) loads the period from duration_ms, clears elapsed time
// and arms the repeat count; a tick word (tuser 0) moves up to tick_ms from the
// remaining to the elapsed time. One result word follows every input word,
// with the times after the word, expired/finished/running flags and alpha:
// start_alpha with fading off, end_alpha for a zero-length period, else
// round((end*elapsed + start*remaining) / period) with halves rounded up,
// taken before any reload. repeat_count 0 reloads forever. With fading on
// the alpha unit runs two passes through its one shared multiplier and then
// eight shift-subtract steps, one quotient bit a cycle. The input is taken
// again as soon as the result sits in the output register. Configuration
// writes are always taken; they must only come while the block is idle.
module repeating_countdown_with_fade_unit #(
  parameter int TIME_WIDTH   = 32,
  parameter int REPEAT_WIDTH = 8
) (
  input  wire                             clk,
  input  wire                             rst,
  // input words
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire  [15:0]                     s_tdata,   // tick_ms[15:0]
  input  wire  [0:0]                      s_tuser,   // opcode[0]
  // result words
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // elapsed_ms[31:0], remaining_ms[63:32], expired[64], finished[65],
  // running[66], alpha[74:67], zero fill[79:75]
  output logic [79:0]                     m_tdata,
  // configuration writes
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [rcdf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [rcdf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rcdf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_CHECK,
    S_ALPHA,
    S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [TIME_WIDTH-1:0]   duration;
  logic [REPEAT_WIDTH-1:0] repeat_count;
  alpha_cfg_t              fade_cfg;

  // timer state
  logic [TIME_WIDTH-1:0]   elapsed;
  logic [TIME_WIDTH-1:0]   remaining;
  logic [REPEAT_WIDTH-1:0] repeats_left;
  logic                    active;

  // captured word and per-word flags
  opcode_t                 opcode;
  logic [TICK_W-1:0]       tick;
  logic                    tick_run;
  logic                    expired_f;
  logic                    finished_f;
  logic                    reload_f;
  logic [ALPHA_W-1:0]      alpha_q;

  logic                    alpha_req;
  alpha_rsp_t              alpha_rsp;

  logic [TIME_WIDTH-1:0]   tick_ext;
  logic [TIME_WIDTH-1:0]   used;
  logic [TIME_WIDTH-1:0]   elapsed_out;
  logic [TIME_WIDTH-1:0]   remaining_out;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // tick time clamped to what is left of the period
  always_comb begin
    tick_ext      = TIME_WIDTH'(tick);
    used          = (tick_ext < remaining) ? tick_ext : remaining;
    // reload happens after alpha, so it is folded in as the result is written
    elapsed_out   = reload_f ? '0 : elapsed;
    remaining_out = reload_f ? duration : remaining;
  end

  rcdf_alpha #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_alpha (
    .clk      (clk),
    .rst      (rst),
    .req      (alpha_req),
    .elapsed  (elapsed),
    .remaining(remaining),
    .cfg      (fade_cfg),
    .rsp      (alpha_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      m_tvalid             <= 1'b0;
      alpha_req            <= 1'b0;
      duration             <= '0;
      repeat_count         <= REPEAT_WIDTH'(1);
      fade_cfg             <= '0;
      elapsed              <= '0;
      remaining            <= '0;
      repeats_left         <= REPEAT_WIDTH'(1);
      active               <= 1'b0;
    end else begin
      // one-cycle request to the alpha unit once the flags are settled
      alpha_req <= (state == S_CHECK);

      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DURATION:     duration             <= TIME_WIDTH'(cfg_data);
          REG_REPEAT_COUNT: repeat_count         <= REPEAT_WIDTH'(cfg_data[7:0]);
          REG_FADE_ENABLE:  fade_cfg.fade_enable <= cfg_data[0];
          REG_START_ALPHA:  fade_cfg.start_alpha <= cfg_data[ALPHA_W-1:0];
          REG_END_ALPHA:    fade_cfg.end_alpha   <= cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end

      // S_OUT sets valid itself when it loads a new word
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            opcode <= opcode_t'(s_tuser[0]);
            tick   <= s_tdata;
            state  <= S_STEP;
          end
        end
        S_STEP: begin
          expired_f  <= 1'b0;
          finished_f <= 1'b0;
          reload_f   <= 1'b0;
          tick_run   <= 1'b0;
          if (opcode == OP_START) begin
            // restart from scratch, also while running
            remaining    <= duration;
            elapsed      <= '0;
            repeats_left <= repeat_count;
            active       <= 1'b1;
          end else if (active) begin
            remaining <= remaining - used;
            elapsed   <= elapsed + used;
            tick_run  <= 1'b1;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (tick_run && remaining == '0) begin
            expired_f <= 1'b1;
            if (repeats_left != '0) begin
              repeats_left <= repeats_left - REPEAT_WIDTH'(1);
              if (repeats_left == REPEAT_WIDTH'(1)) begin
                // last limited period: stop without reload
                finished_f <= 1'b1;
                active     <= 1'b0;
              end else begin
                reload_f <= 1'b1;
              end
            end else begin
              // endless mode
              reload_f <= 1'b1;
            end
          end
          state <= S_ALPHA;
        end
        S_ALPHA: begin
          if (alpha_rsp.done) begin
            alpha_q <= alpha_rsp.alpha;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          // wait for a free output register
          if (!m_tvalid || m_tready) begin
            m_tdata   <= {5'b0, alpha_q, active, finished_f, expired_f,
                          32'(remaining_out), 32'(elapsed_out)};
            m_tvalid  <= 1'b1;
            elapsed   <= elapsed_out;
            remaining <= remaining_out;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the alpha unit only answers while a word waits for it
  assert property (@(posedge clk) disable iff (rst)
    alpha_rsp.done |-> state == S_ALPHA)
    else $error("alpha response outside the alpha wait");

  // a finished period is always an expired one and leaves the timer stopped
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[65] |-> m_tdata[64] && !m_tdata[66])
    else $error("finished without expiry or still running");

  // one word at a time: no second word right after acceptance
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while a word is in flight");

endmodule

`default_nettype wire
